>>> sv/tcme_pkg.sv
// Types, codes, byte constants and helpers shared by the cursor motion encoder.
package tcme_pkg;

  localparam int unsigned PosW    = 7;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PcW     = 5;
  localparam int unsigned CostW   = 9;

  typedef logic [PosW-1:0]  pos_t;
  typedef logic [PosW:0]    row_t;   // work row, one past the widest screen during a wrap
  typedef logic [CostW-1:0] cost_t;
  typedef logic [CharW-1:0] byte_t;
  typedef logic [PcW-1:0]   pc_t;

  localparam pos_t ResetRows = 7'd24;
  localparam pos_t ResetCols = 7'd80;

  localparam logic [CfgIdxW-1:0] CFG_ROWS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLS = 2'd1;

  localparam byte_t CH_HOME  = 8'h1E;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_UP    = 8'h0B;
  localparam byte_t CH_DOWN  = 8'h0A;
  localparam byte_t CH_LEFT  = 8'h08;
  localparam byte_t CH_RIGHT = 8'h0C;
  localparam byte_t CH_ESC   = 8'h1B;
  localparam byte_t CH_EQ    = 8'h3D;
  localparam byte_t CH_BEL   = 8'h07;
  localparam byte_t PosBias  = 8'd32;
  localparam cost_t LoadCost = 9'd4;

  typedef enum logic [1:0] {
    REQ_GOTO  = 2'd0,
    REQ_PRINT = 2'd1,
    REQ_HOME  = 2'd2,
    REQ_BELL  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    PLAN_LOAD = 2'd0,
    PLAN_HOME = 2'd1,
    PLAN_CR   = 2'd2,
    PLAN_REL  = 2'd3
  } plan_e;

  typedef enum logic [3:0] {
    BYTE_NONE, BYTE_CHAR, BYTE_HOME, BYTE_CR, BYTE_BEL, BYTE_ESC, BYTE_EQ,
    BYTE_ROWPOS, BYTE_COLPOS, BYTE_ROWSTEP, BYTE_COLSTEP
  } byte_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD_REQ, OP_TGT_GOTO, OP_TGT_WRAP, OP_COSTS, OP_PICK,
    OP_HOME_CUR, OP_CR_CUR, OP_ROW_STEP, OP_COL_STEP, OP_PRINT_ADV,
    OP_COMMIT, OP_FLUSH
  } op_e;

  typedef enum logic [3:0] {
    CND_NEXT, CND_ALWAYS, CND_GOTO, CND_PRINT, CND_HOME, CND_CORNER,
    CND_NO_WRAP, CND_PLAN_LOAD, CND_PLAN_CR, CND_PLAN_REL, CND_ROW_DONE,
    CND_COL_DONE
  } cond_e;

  // microcode addresses
  localparam pc_t U_FETCH     = 5'd0;
  localparam pc_t U_BR_GOTO   = 5'd1;
  localparam pc_t U_BR_PRINT  = 5'd2;
  localparam pc_t U_BR_HOME   = 5'd3;
  localparam pc_t U_BELL      = 5'd4;
  localparam pc_t U_HOME      = 5'd5;
  localparam pc_t U_PRINT     = 5'd6;
  localparam pc_t U_CHAR      = 5'd7;
  localparam pc_t U_WRAP      = 5'd8;
  localparam pc_t U_GOTO      = 5'd9;
  localparam pc_t U_COST      = 5'd10;
  localparam pc_t U_PICK      = 5'd11;
  localparam pc_t U_BR_LOAD   = 5'd12;
  localparam pc_t U_BR_CR     = 5'd13;
  localparam pc_t U_BR_REL    = 5'd14;
  localparam pc_t U_PLAN_HOME = 5'd15;
  localparam pc_t U_PLAN_CR   = 5'd16;
  localparam pc_t U_ROW       = 5'd17;
  localparam pc_t U_ROW_STEP  = 5'd18;
  localparam pc_t U_COL       = 5'd19;
  localparam pc_t U_COL_STEP  = 5'd20;
  localparam pc_t U_ESC       = 5'd21;
  localparam pc_t U_EQ        = 5'd22;
  localparam pc_t U_ROWPOS    = 5'd23;
  localparam pc_t U_COLPOS    = 5'd24;
  localparam pc_t U_END       = 5'd25;

  typedef struct packed {
    byte_e sel;
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   en;
  } ctrl_t;

  typedef struct packed {
    logic is_goto;
    logic is_print;
    logic is_home;
    logic corner;
    logic no_wrap;
    logic plan_load;
    logic plan_cr;
    logic plan_rel;
    logic row_done;
    logic col_done;
    logic out_blocked;
  } dp_flags_t;

  // below 1 becomes 1, then above the limit becomes the limit
  function automatic pos_t clamp_pos(row_t v, pos_t lim);
    row_t t;
    t = (v == '0) ? row_t'(1) : v;
    if (t > {1'b0, lim}) t = {1'b0, lim};
    return t[PosW-1:0];
  endfunction

  function automatic row_t abs_diff(row_t a, row_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> sv/tcme_ucode_rom.sv
// Microcode program: one control word per step address.
module tcme_ucode_rom (
  input  tcme_pkg::pc_t    pc_i,
  output tcme_pkg::uword_t uw_o
);
  import tcme_pkg::*;

  function automatic uword_t w(byte_e s, op_e o, cond_e c, pc_t t);
    uword_t r;
    r.sel    = s;
    r.op     = o;
    r.cond   = c;
    r.target = t;
    return r;
  endfunction

  always_comb begin
    unique case (pc_i)
      U_FETCH:     uw_o = w(BYTE_NONE,    OP_LOAD_REQ,  CND_NEXT,      U_FETCH);
      U_BR_GOTO:   uw_o = w(BYTE_NONE,    OP_NOP,       CND_GOTO,      U_GOTO);
      U_BR_PRINT:  uw_o = w(BYTE_NONE,    OP_NOP,       CND_PRINT,     U_PRINT);
      U_BR_HOME:   uw_o = w(BYTE_NONE,    OP_NOP,       CND_HOME,      U_HOME);
      U_BELL:      uw_o = w(BYTE_BEL,     OP_NOP,       CND_ALWAYS,    U_END);
      U_HOME:      uw_o = w(BYTE_HOME,    OP_HOME_CUR,  CND_ALWAYS,    U_END);
      U_PRINT:     uw_o = w(BYTE_NONE,    OP_NOP,       CND_CORNER,    U_END);
      U_CHAR:      uw_o = w(BYTE_CHAR,    OP_PRINT_ADV, CND_NO_WRAP,   U_END);
      U_WRAP:      uw_o = w(BYTE_NONE,    OP_TGT_WRAP,  CND_ALWAYS,    U_COST);
      U_GOTO:      uw_o = w(BYTE_NONE,    OP_TGT_GOTO,  CND_NEXT,      U_FETCH);
      U_COST:      uw_o = w(BYTE_NONE,    OP_COSTS,     CND_NEXT,      U_FETCH);
      U_PICK:      uw_o = w(BYTE_NONE,    OP_PICK,      CND_NEXT,      U_FETCH);
      U_BR_LOAD:   uw_o = w(BYTE_NONE,    OP_NOP,       CND_PLAN_LOAD, U_ESC);
      U_BR_CR:     uw_o = w(BYTE_NONE,    OP_NOP,       CND_PLAN_CR,   U_PLAN_CR);
      U_BR_REL:    uw_o = w(BYTE_NONE,    OP_NOP,       CND_PLAN_REL,  U_ROW);
      U_PLAN_HOME: uw_o = w(BYTE_HOME,    OP_HOME_CUR,  CND_ALWAYS,    U_ROW);
      U_PLAN_CR:   uw_o = w(BYTE_CR,      OP_CR_CUR,    CND_NEXT,      U_FETCH);
      U_ROW:       uw_o = w(BYTE_NONE,    OP_NOP,       CND_ROW_DONE,  U_COL);
      U_ROW_STEP:  uw_o = w(BYTE_ROWSTEP, OP_ROW_STEP,  CND_ALWAYS,    U_ROW);
      U_COL:       uw_o = w(BYTE_NONE,    OP_NOP,       CND_COL_DONE,  U_END);
      U_COL_STEP:  uw_o = w(BYTE_COLSTEP, OP_COL_STEP,  CND_ALWAYS,    U_COL);
      U_ESC:       uw_o = w(BYTE_ESC,     OP_NOP,       CND_NEXT,      U_FETCH);
      U_EQ:        uw_o = w(BYTE_EQ,      OP_NOP,       CND_NEXT,      U_FETCH);
      U_ROWPOS:    uw_o = w(BYTE_ROWPOS,  OP_NOP,       CND_NEXT,      U_FETCH);
      U_COLPOS:    uw_o = w(BYTE_COLPOS,  OP_COMMIT,    CND_NEXT,      U_FETCH);
      U_END:       uw_o = w(BYTE_NONE,    OP_FLUSH,     CND_ALWAYS,    U_FETCH);
      default:     uw_o = w(BYTE_NONE,    OP_NOP,       CND_ALWAYS,    U_FETCH);
    endcase
  end

endmodule

>>> sv/tcme_sequencer.sv
// Step counter, jump conditions and stall control for the microcode program.
module tcme_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcme_pkg::dp_flags_t flags_i,
  input  tcme_pkg::uword_t    uw_i,
  output tcme_pkg::pc_t       pc_o,
  output tcme_pkg::ctrl_t     ctrl_o
);
  import tcme_pkg::*;

  pc_t  pc_q, pc_d;
  logic take;
  logic stall;

  always_comb begin
    unique case (uw_i.cond)
      CND_NEXT:      take = 1'b0;
      CND_ALWAYS:    take = 1'b1;
      CND_GOTO:      take = flags_i.is_goto;
      CND_PRINT:     take = flags_i.is_print;
      CND_HOME:      take = flags_i.is_home;
      CND_CORNER:    take = flags_i.corner;
      CND_NO_WRAP:   take = flags_i.no_wrap;
      CND_PLAN_LOAD: take = flags_i.plan_load;
      CND_PLAN_CR:   take = flags_i.plan_cr;
      CND_PLAN_REL:  take = flags_i.plan_rel;
      CND_ROW_DONE:  take = flags_i.row_done;
      CND_COL_DONE:  take = flags_i.col_done;
      default:       take = 1'b0;
    endcase
  end

  // a byte can only move into the output register when it is free
  assign stall = ((pc_q == U_FETCH) && !in_valid_i) ||
                 ((uw_i.sel != BYTE_NONE) && flags_i.out_blocked) ||
                 ((uw_i.op == OP_FLUSH) && flags_i.out_blocked);

  always_comb begin
    if (stall) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw_i.target;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= U_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_ready_o = (pc_q == U_FETCH);
  assign pc_o       = pc_q;
  assign ctrl_o.uw  = uw_i;
  assign ctrl_o.en  = !stall;

endmodule

>>> sv/tcme_datapath.sv
// Cursor, target, plan costs, byte select and the hold/output byte registers.
module tcme_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcme_pkg::ctrl_t     ctrl_i,
  output tcme_pkg::dp_flags_t flags_o,
  input  logic [1:0]          req_type_i,
  input  logic [6:0]          target_row_i,
  input  logic [6:0]          target_col_i,
  input  logic [7:0]          print_char_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [6:0]          cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);
  import tcme_pkg::*;

  pos_t  rows_q, cols_q;
  row_t  cur_row_q, cur_row_d;
  pos_t  cur_col_q, cur_col_d;
  req_e  req_q;
  pos_t  in_row_q, in_col_q;
  byte_t char_q;
  pos_t  ty_q, ty_d, tx_q, tx_d;
  cost_t c1_q, c2_q, c3_q;
  plan_e plan_q;
  logic  hold_valid_q, hold_valid_d;
  byte_t hold_byte_q;
  logic  out_valid_q, out_valid_d;
  byte_t out_byte_q;
  logic  out_last_q;

  logic  do_op, emit, flush, push;
  byte_t new_byte;
  row_t  ty_w, tx_w, col_w;
  row_t  d_row, d_col, d_ty1, d_tx1;
  plan_e best;
  cost_t best_cost;

  assign do_op = ctrl_i.en;
  assign emit  = do_op && (ctrl_i.uw.sel != BYTE_NONE);
  assign flush = do_op && (ctrl_i.uw.op == OP_FLUSH) && hold_valid_q;
  assign push  = (emit && hold_valid_q) || flush;

  assign ty_w  = {1'b0, ty_q};
  assign tx_w  = {1'b0, tx_q};
  assign col_w = {1'b0, cur_col_q};

  assign d_row = abs_diff(cur_row_q, ty_w);
  assign d_col = abs_diff(col_w, tx_w);
  assign d_ty1 = abs_diff(row_t'(1), ty_w);
  assign d_tx1 = abs_diff(row_t'(1), tx_w);

  // earlier plan wins on equal cost
  always_comb begin
    best      = PLAN_LOAD;
    best_cost = LoadCost;
    if (c1_q < best_cost) begin
      best      = PLAN_HOME;
      best_cost = c1_q;
    end
    if (c2_q < best_cost) begin
      best      = PLAN_CR;
      best_cost = c2_q;
    end
    if (c3_q < best_cost) begin
      best = PLAN_REL;
    end
  end

  always_comb begin
    case (ctrl_i.uw.sel)
      BYTE_CHAR:    new_byte = char_q;
      BYTE_HOME:    new_byte = CH_HOME;
      BYTE_CR:      new_byte = CH_CR;
      BYTE_BEL:     new_byte = CH_BEL;
      BYTE_ESC:     new_byte = CH_ESC;
      BYTE_EQ:      new_byte = CH_EQ;
      BYTE_ROWPOS:  new_byte = byte_t'(ty_q) + PosBias - byte_t'(1);
      BYTE_COLPOS:  new_byte = byte_t'(tx_q) + PosBias - byte_t'(1);
      BYTE_ROWSTEP: new_byte = (ty_w < cur_row_q) ? CH_UP : CH_DOWN;
      BYTE_COLSTEP: new_byte = (tx_q < cur_col_q) ? CH_LEFT : CH_RIGHT;
      default:      new_byte = '0;
    endcase
  end

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    ty_d      = ty_q;
    tx_d      = tx_q;
    if (do_op) begin
      case (ctrl_i.uw.op)
        OP_TGT_GOTO: begin
          ty_d = clamp_pos({1'b0, in_row_q}, rows_q);
          tx_d = clamp_pos({1'b0, in_col_q}, cols_q);
        end
        OP_TGT_WRAP: begin
          // cursor to the start of the next row, then aim back at the last column
          ty_d      = clamp_pos(cur_row_q, rows_q);
          tx_d      = clamp_pos({1'b0, cols_q}, cols_q);
          cur_row_d = cur_row_q + row_t'(1);
          cur_col_d = pos_t'(1);
        end
        OP_HOME_CUR: begin
          cur_row_d = row_t'(1);
          cur_col_d = pos_t'(1);
        end
        OP_CR_CUR:    cur_col_d = pos_t'(1);
        OP_ROW_STEP:  cur_row_d = (ty_w < cur_row_q) ? cur_row_q - row_t'(1)
                                                     : cur_row_q + row_t'(1);
        OP_COL_STEP:  cur_col_d = (tx_q < cur_col_q) ? cur_col_q - pos_t'(1)
                                                     : cur_col_q + pos_t'(1);
        OP_PRINT_ADV: begin
          if (cur_col_q < cols_q) cur_col_d = cur_col_q + pos_t'(1);
        end
        OP_COMMIT: begin
          cur_row_d = ty_w;
          cur_col_d = tx_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (emit) begin
      hold_valid_d = 1'b1;
    end else if (flush) begin
      hold_valid_d = 1'b0;
    end
  end

  always_comb begin
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q       <= ResetRows;
      cols_q       <= ResetCols;
      cur_row_q    <= row_t'(1);
      cur_col_q    <= pos_t'(1);
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == CFG_ROWS)) rows_q <= cfg_data_i;
      if (cfg_valid_i && (cfg_index_i == CFG_COLS)) cols_q <= cfg_data_i;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ty_q <= ty_d;
    tx_q <= tx_d;
    if (do_op && (ctrl_i.uw.op == OP_LOAD_REQ)) begin
      req_q    <= req_e'(req_type_i);
      in_row_q <= target_row_i;
      in_col_q <= target_col_i;
      char_q   <= print_char_i;
    end
    if (do_op && (ctrl_i.uw.op == OP_COSTS)) begin
      c1_q <= cost_t'(1) + cost_t'(d_ty1) + cost_t'(d_tx1);
      c2_q <= cost_t'(1) + cost_t'(d_row) + cost_t'(d_tx1);
      c3_q <= cost_t'(d_row) + cost_t'(d_col);
    end
    if (do_op && (ctrl_i.uw.op == OP_PICK)) plan_q <= best;
    if (emit) hold_byte_q <= new_byte;
    if (push) begin
      out_byte_q <= hold_byte_q;
      out_last_q <= flush;
    end
  end

  assign flags_o.is_goto     = (req_q == REQ_GOTO);
  assign flags_o.is_print    = (req_q == REQ_PRINT);
  assign flags_o.is_home     = (req_q == REQ_HOME);
  assign flags_o.corner      = (cur_col_q == cols_q) && (cur_row_q == {1'b0, rows_q});
  assign flags_o.no_wrap     = (cur_col_q < cols_q);
  assign flags_o.plan_load   = (plan_q == PLAN_LOAD);
  assign flags_o.plan_cr     = (plan_q == PLAN_CR);
  assign flags_o.plan_rel    = (plan_q == PLAN_REL);
  assign flags_o.row_done    = (cur_row_q == ty_w);
  assign flags_o.col_done    = (cur_col_q == tx_q);
  assign flags_o.out_blocked = hold_valid_q && out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

>>> sv/terminal_cursor_motion_encoder.sv
// Top level of the terminal cursor motion encoder.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | req_type, target_row, target_col, print_char
//   out     | output    | out_valid_o/out_ready_i | out_byte, out_last
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index (0 rows, 1 cols), cfg_data
//
// The microcode sequencer issues one control word per cycle unless an empty input or a
// blocked output stalls it, and each cursor step byte costs two words (test, then step).
// Bytes pass through a one-deep hold register so the last flag is known; the final
// byte leaves at the end step. A stalled output freezes the sequencer at its next
// byte or end step.
// Reset loads 24 rows, 80 columns and cursor (1,1); no clearing pass.
module terminal_cursor_motion_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [6:0] target_row_i,
  input  logic [6:0] target_col_i,
  input  logic [7:0] print_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);
  import tcme_pkg::*;

  pc_t       pc;
  uword_t    uw;
  ctrl_t     ctrl;
  dp_flags_t flags;

  assign cfg_ready_o = 1'b1;

  tcme_ucode_rom u_rom (
    .pc_i (pc),
    .uw_o (uw)
  );

  tcme_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .flags_i    (flags),
    .uw_i       (uw),
    .pc_o       (pc),
    .ctrl_o     (ctrl)
  );

  tcme_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .flags_o      (flags),
    .req_type_i   (req_type_i),
    .target_row_i (target_row_i),
    .target_col_i (target_col_i),
    .print_char_i (print_char_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o)
  );

endmodule

>>> sv/tcme_checker.sv
// Port-level checks on the cursor motion encoder, bound to the top level.
module tcme_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // a stalled output item is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_byte_o) && $stable(out_last_o))
    else $error("output item changed while stalled");

  // ready for a new item only once the previous item's last byte has reached the output
  a_ready_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_last_o)
    else $error("new item taken before the previous item finished");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("two items accepted back to back");

endmodule

bind terminal_cursor_motion_encoder tcme_checker u_tcme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

>>> verif/terminal_cursor_motion_encoder_test.sv
// Self-checking testbench for the terminal cursor motion encoder.
`timescale 1ns / 100ps

module terminal_cursor_motion_encoder_test;
  import tcme_pkg::*;

  localparam int SettleCycles = 40;   // covers the slowest request that sends nothing
  localparam int HoldCycles   = 200;
  localparam logic [1:0] CFG_SPARE    = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    byte_t data;
    logic  last;
  } serial_byte_t;

  // Predicts the serial byte stream and keeps the bytes still owed by the block.
  class cursor_scoreboard;
    pos_t         rows, cols, cur_row, cur_col;
    serial_byte_t owed[$];
    int           errors;

    function new();
      rows    = ResetRows;
      cols    = ResetCols;
      cur_row = 7'd1;
      cur_col = 7'd1;
      errors  = 0;
    endfunction

    function void note_config(logic [1:0] idx, pos_t data);
      if (idx == CFG_ROWS) rows = data;
      else if (idx == CFG_COLS) cols = data;
    endfunction

    function int span(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void owe(byte_t b);
      owed.push_back('{data: b, last: 1'b0});
    endfunction

    // cheapest way from (cr,cc) to the clamped target; ties go to the earlier plan
    function void plan_move(int ty, int tx, inout int cr, inout int cc);
      int    c_home, c_cr, c_rel, best;
      plan_e plan;
      if (ty < 1) ty = 1;
      if (tx < 1) tx = 1;
      if (ty > int'(rows)) ty = int'(rows);
      if (tx > int'(cols)) tx = int'(cols);
      c_home = 1 + span(1, ty) + span(1, tx);
      c_cr   = 1 + span(cr, ty) + span(1, tx);
      c_rel  = span(cr, ty) + span(cc, tx);
      best   = int'(LoadCost);
      plan   = PLAN_LOAD;
      if (c_home < best) begin
        best = c_home;
        plan = PLAN_HOME;
      end
      if (c_cr < best) begin
        best = c_cr;
        plan = PLAN_CR;
      end
      if (c_rel < best) begin
        best = c_rel;
        plan = PLAN_REL;
      end
      if (plan == PLAN_LOAD) begin
        owe(CH_ESC);
        owe(CH_EQ);
        owe(byte_t'(int'(PosBias) + ty - 1));
        owe(byte_t'(int'(PosBias) + tx - 1));
      end else begin
        if (plan == PLAN_HOME) begin
          owe(CH_HOME);
          cr = 1;
          cc = 1;
        end else if (plan == PLAN_CR) begin
          owe(CH_CR);
          cc = 1;
        end
        repeat (span(cr, ty)) owe((ty < cr) ? CH_UP : CH_DOWN);
        repeat (span(cc, tx)) owe((tx < cc) ? CH_LEFT : CH_RIGHT);
      end
      cr = ty;
      cc = tx;
    endfunction

    function void note_request(req_e kind, pos_t trow, pos_t tcol, byte_t ch);
      int cr, cc, n0;
      cr = int'(cur_row);
      cc = int'(cur_col);
      n0 = owed.size();
      case (kind)
        REQ_GOTO: plan_move(int'(trow), int'(tcol), cr, cc);
        REQ_PRINT: begin
          // bottom-right cell prints nothing, so the screen never scrolls
          if (!(cc == int'(cols) && cr == int'(rows))) begin
            owe(ch);
            if (cc < int'(cols)) begin
              cc++;
            end else begin
              cr++;
              cc = 1;
              plan_move(cr - 1, int'(cols), cr, cc);
            end
          end
        end
        REQ_HOME: begin
          owe(CH_HOME);
          cr = 1;
          cc = 1;
        end
        default: owe(CH_BEL);
      endcase
      if (owed.size() > n0) owed[owed.size()-1].last = 1'b1;
      cur_row = pos_t'(cr);
      cur_col = pos_t'(cc);
    endfunction

    function void check_byte(byte_t b, logic last);
      serial_byte_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual %02h last %0b", $time, b, last);
        return;
      end
      want = owed.pop_front();
      if (want.data !== b) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time, want.data, b);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: out_last mismatch: expected %0b, actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i   = '0;
  logic [6:0] target_row_i = '0;
  logic [6:0] target_col_i = '0;
  logic [7:0] print_char_i = '0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       cfg_valid_i  = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i  = '0;
  logic [6:0] cfg_data_i   = '0;

  cursor_scoreboard sb = new();

  int hold_tokens = 0;   // bumped by the sender side to request a long receiver hold-off
  int hold_taken  = 0;
  int hold_left   = 0;
  int stall_left  = 0;
  int rx_mode     = 0;
  int rx_mode_left = 0;
  int burst_left  = 0;
  int rush_left   = 0;

  terminal_cursor_motion_encoder uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("terminal_cursor_motion_encoder_test: FAIL");
    $finish;
  end

  // receiver: checks each byte and stalls on its own pattern
  always @(posedge clk_i) begin : receiver
    logic rdy;
    if (out_valid_o && out_ready_i) sb.check_byte(out_byte_o, out_last_o);
    if (hold_tokens != hold_taken) begin
      hold_taken++;
      hold_left = HoldCycles;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(20, 120);
    end else begin
      rx_mode_left--;
    end
    rdy = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if ((rx_mode == 1 && $urandom_range(0, 3) == 0) ||
                 (rx_mode == 2 && $urandom_range(0, 9) < 6)) begin
      stall_left = $urandom_range(0, 7);
      rdy = 1'b0;
    end
    out_ready_i <= rdy;
  end

  task automatic send_req(req_e kind, pos_t trow, pos_t tcol, byte_t ch);
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    target_row_i <= trow;
    target_col_i <= tcol;
    print_char_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(kind, trow, tcol, ch);
  endtask

  task automatic cfg_write(logic [1:0] idx, pos_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, data);
  endtask

  task automatic set_screen(pos_t r, pos_t c);
    cfg_write(CFG_ROWS, r);
    cfg_write(CFG_COLS, c);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering items until every owed byte is out and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int gap;
    if (rush_left > 0) begin
      rush_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic int at_least_one(int v);
    return (v < 1) ? 1 : v;
  endfunction

  function automatic pos_t near(pos_t p);
    int v;
    v = int'(p) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 127) v = 127;
    return pos_t'(v);
  endfunction

  task automatic random_request();
    int   pick;
    pos_t tr, tc;
    pick = $urandom_range(0, 99);
    tr   = pos_t'($urandom);
    tc   = pos_t'($urandom);
    if (pick < 45) begin
      case ($urandom_range(0, 3))
        1: begin
          tr = near(sb.cur_row);
          tc = near(sb.cur_col);
        end
        2: begin
          tr = near(sb.cur_row);
          tc = pos_t'($urandom_range(1, at_least_one(int'(sb.cols))));
        end
        3: begin
          tr = pos_t'($urandom_range(1, at_least_one(int'(sb.rows))));
          tc = pos_t'($urandom_range(1, at_least_one(int'(sb.cols))));
        end
        default: ;
      endcase
      send_req(REQ_GOTO, tr, tc, byte_t'($urandom));
    end else if (pick < 80) begin
      send_req(REQ_PRINT, tr, tc, byte_t'($urandom));
    end else if (pick < 90) begin
      send_req(REQ_HOME, tr, tc, byte_t'($urandom));
    end else begin
      send_req(REQ_BELL, tr, tc, byte_t'($urandom));
    end
  endtask

  task automatic run_phase(pos_t r, pos_t c, int n_items, bit with_hold);
    int   sent, n_print, col;
    pos_t row;
    bit   held;
    drain();
    set_screen(r, c);
    sent = 0;
    held = 1'b0;
    while (sent < n_items) begin
      if (with_hold && !held && sent >= n_items / 3) begin
        // receiver goes quiet while the sender keeps offering back to back
        held = 1'b1;
        hold_tokens <= hold_tokens + 1;
        rush_left = 24;
      end
      if ($urandom_range(0, 3) == 0) begin
        // line run: land near the right edge, then print across it
        row = pos_t'($urandom_range(1, at_least_one(int'(sb.rows))));
        col = int'(sb.cols) - int'($urandom_range(0, 3));
        idle_gap();
        send_req(REQ_GOTO, row, pos_t'((col < 0) ? 0 : col), byte_t'($urandom));
        n_print = $urandom_range(2, 5);
        repeat (n_print) begin
          idle_gap();
          send_req(REQ_PRINT, pos_t'($urandom), pos_t'($urandom), byte_t'($urandom));
        end
        sent += n_print + 1;
      end else begin
        idle_gap();
        random_request();
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default 24 x 80 screen, cursor at home
    send_req(REQ_BELL, 7'd0, 7'd0, 8'h00);
    send_req(REQ_GOTO, 7'd1, 7'd1, 8'hFF);       // already there: nothing sent
    send_req(REQ_GOTO, 7'd0, 7'd0, 8'h00);       // clamps up to the current cell
    send_req(REQ_GOTO, 7'd127, 7'd127, 8'h00);   // clamps down, load-cursor escape
    send_req(REQ_GOTO, 7'd24, 7'd79, 8'h00);
    send_req(REQ_PRINT, 7'd0, 7'd0, 8'hFF);
    send_req(REQ_PRINT, 7'd127, 7'd127, 8'h00);  // bottom-right: suppressed
    send_req(REQ_HOME, 7'h55, 7'h2A, 8'hAA);
    send_req(REQ_GOTO, 7'd3, 7'd2, 8'h55);
    send_req(REQ_GOTO, 7'd3, 7'd40, 8'h00);
    send_req(REQ_GOTO, 7'd5, 7'd1, 8'h00);       // carriage return plan
    send_req(REQ_GOTO, 7'd2, 7'd2, 8'h00);       // home plan
    send_req(REQ_GOTO, 7'd1, 7'd80, 8'h00);
    send_req(REQ_PRINT, 7'd0, 7'd0, 8'h41);      // last column: wrap and come back
    send_req(REQ_GOTO, 7'd1, 7'd3, 8'h00);
    send_req(REQ_GOTO, 7'd1, 7'd1, 8'h00);       // home ties carriage return
    send_req(REQ_PRINT, 7'd0, 7'd0, 8'h55);

    // one-cell screen
    drain();
    set_screen(7'd1, 7'd1);
    send_req(REQ_PRINT, 7'd0, 7'd0, 8'h5A);
    send_req(REQ_GOTO, 7'd127, 7'd0, 8'h00);

    // rows register of zero: load-cursor row byte falls below the bias
    drain();
    set_screen(7'd96, 7'd96);
    send_req(REQ_GOTO, 7'd50, 7'd50, 8'h00);
    drain();
    cfg_write(CFG_ROWS, 7'd0);
    cfg_write(CFG_SPARE, 7'h2A);
    cfg_write(CFG_SPARE_HI, 7'h55);
    cfg_valid_i <= 1'b0;
    send_req(REQ_GOTO, 7'd1, 7'd10, 8'h00);

    // widest screen, then shrink under a cursor sitting far out
    drain();
    set_screen(7'd127, 7'd127);
    send_req(REQ_GOTO, 7'd127, 7'd126, 8'h00);
    send_req(REQ_PRINT, 7'd0, 7'd0, 8'hC3);
    send_req(REQ_PRINT, 7'd0, 7'd0, 8'h3C);
    drain();
    set_screen(7'd5, 7'd127);
    send_req(REQ_PRINT, 7'd0, 7'd0, 8'h81);
    drain();
    set_screen(7'd10, 7'd10);
    send_req(REQ_PRINT, 7'd0, 7'd0, 8'h7E);

    run_phase(ResetRows, ResetCols, 50, 1'b1);
    run_phase(7'd1, 7'd1, 20, 1'b0);
    run_phase(7'd96, 7'd96, 30, 1'b0);
    run_phase(7'd3, 7'd5, 40, 1'b1);
    run_phase(7'd127, 7'd127, 25, 1'b0);
    run_phase(7'd0, 7'd0, 15, 1'b0);
    run_phase(7'd7, 7'd12, 25, 1'b0);

    drain();
    if (sb.errors == 0) begin
      $display("terminal_cursor_motion_encoder_test: PASS");
    end else begin
      $display("terminal_cursor_motion_encoder_test: FAIL");
    end
    $finish;
  end

endmodule
